>>> design/flow_traffic_class_heuristic_unit_defines.svh
// ----------------------------------------------------------------------------
// Flow traffic class heuristic - assertion macros
// Concurrent check macros; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FLOW_TRAFFIC_CLASS_HEURISTIC_UNIT_DEFINES_SVH
`define FLOW_TRAFFIC_CLASS_HEURISTIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FTCH_ASSERT_IMP(label, clock, rst_n, cond, expr) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) \
		(cond) |-> (expr)) else $error("ftch check failed");
`define FTCH_ASSERT_NEXT(label, clock, rst_n, cond, expr) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) \
		(cond) |=> (expr)) else $error("ftch check failed");
`else
`define FTCH_ASSERT_IMP(label, clock, rst_n, cond, expr)
`define FTCH_ASSERT_NEXT(label, clock, rst_n, cond, expr)
`endif

`endif

>>> design/ftch_pkg.sv
// ----------------------------------------------------------------------------
// ftch_pkg
// Types, field widths, thresholds and class codes of the flow classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ftch_pkg;

	localparam int PORT_W = 16;
	localparam int SIZE_W = 20;
	localparam int RATE_W = 24;
	localparam int BYTE_W = 32;
	localparam int RATIO_W = 17;
	localparam int CLASS_W = 3;
	localparam int CONF_W = 7;

	localparam int IN_TDATA_W = 128;
	localparam int OUT_TDATA_W = 16;

	typedef logic [PORT_W-1:0] port_t;
	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [RATE_W-1:0] rate_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [RATIO_W-1:0] ratio_t;
	typedef logic [CLASS_W-1:0] class_t;
	typedef logic [CONF_W-1:0] conf_t;

	// class codes
	localparam class_t CLS_VIDEO = 3'd0;
	localparam class_t CLS_SOCIAL = 3'd1;
	localparam class_t CLS_VOIP = 3'd2;
	localparam class_t CLS_GAMING = 3'd3;
	localparam class_t CLS_DOWNLOAD = 3'd4;
	localparam class_t CLS_BROWSING = 3'd5;
	localparam class_t CLS_OTHER = 3'd6;

	// confidences
	localparam conf_t CONF_DNS = 7'd95;
	localparam conf_t CONF_INFRA = 7'd90;
	localparam conf_t CONF_SIP = 7'd90;
	localparam conf_t CONF_VOICE = 7'd82;
	localparam conf_t CONF_GAME_PAT = 7'd72;
	localparam conf_t CONF_GAME_PORT = 7'd70;
	localparam conf_t CONF_VIDEO = 7'd75;
	localparam conf_t CONF_FAST_DL = 7'd72;
	localparam conf_t CONF_BIG_DL = 7'd65;
	localparam conf_t CONF_SOCIAL = 7'd50;
	localparam conf_t CONF_WEB = 7'd55;
	localparam conf_t CONF_FALLBACK = 7'd30;
	localparam conf_t CONF_MAX = 7'd95;

	// ports
	localparam port_t P_DNS = 16'd53;
	localparam port_t P_NTP = 16'd123;
	localparam port_t P_SNMP = 16'd161;
	localparam port_t P_MDNS = 16'd5353;
	localparam port_t P_SIP = 16'd5060;
	localparam port_t P_SIPS = 16'd5061;
	localparam port_t P_GAME_A_LO = 16'd7000;
	localparam port_t P_GAME_A_HI = 16'd8000;
	localparam port_t P_GAME_B_LO = 16'd27000;
	localparam port_t P_GAME_B_HI = 16'd28000;
	localparam port_t P_STUN = 16'd3478;
	localparam port_t P_STUN_ALT = 16'd3479;
	localparam port_t P_HTTPS = 16'd443;
	localparam port_t P_HTTP = 16'd80;

	// packet size, Q16.4
	localparam size_t SZ_60 = 20'd960;
	localparam size_t SZ_200 = 20'd3200;
	localparam size_t SZ_300 = 20'd4800;
	localparam size_t SZ_800 = 20'd12800;
	localparam size_t SZ_1000 = 20'd16000;
	localparam size_t SZ_1200 = 20'd19200;

	// packet rate, Q20.4
	localparam rate_t PR_20 = 24'd320;
	localparam rate_t PR_30 = 24'd480;
	localparam rate_t PR_120 = 24'd1920;

	// byte rate
	localparam byte_t BR_5K = 32'd5000;
	localparam byte_t BR_100K = 32'd100000;
	localparam byte_t BR_200K = 32'd200000;
	localparam byte_t BR_500K = 32'd500000;

	// forward ratio, Q1.16; "below t" limits are the largest raw value under t
	localparam ratio_t FR_QUARTER = 17'd16384;
	localparam ratio_t FR_THREEQ = 17'd49152;
	localparam ratio_t FR_MAX_015 = 17'd9830;
	localparam ratio_t FR_MAX_010 = 17'd6553;
	localparam ratio_t FR_MAX_005 = 17'd3276;

	typedef struct packed {
		port_t dest_port;
		port_t source_port;
		logic is_udp;
		size_t mean_packet_size;
		rate_t packet_rate;
		byte_t byte_rate;
		ratio_t forward_ratio;
	} flow_t;

	// stage 1 comparison flags
	typedef struct packed {
		logic dns;
		logic infra;
		logic sip;
		logic udp;
		logic game_port;
		logic port_443;
		logic web_port;
		logic sz_gt60;
		logic sz_lt300;
		logic sz_lt200;
		logic sz_gt200;
		logic sz_lt800;
		logic sz_gt1000;
		logic sz_gt1200;
		logic pr_gt20;
		logic pr_lt120;
		logic pr_gt30;
		logic fr_mid;
		logic fr_le015;
		logic fr_le010;
		logic fr_le005;
		logic br_gt5k;
		logic br_lt100k;
		logic br_gt100k;
		logic br_gt200k;
		logic br_gt500k;
	} feat_t;

	// stage 2 rule matches, fallback not listed
	typedef struct packed {
		logic dns;
		logic infra;
		logic sip;
		logic voice;
		logic game_pat;
		logic game_port;
		logic video;
		logic fast_dl;
		logic big_dl;
		logic social;
		logic web;
	} hits_t;

	typedef struct packed {
		conf_t confidence_percent;
		class_t class_code;
	} result_t;

endpackage

`default_nettype wire

>>> design/flow_traffic_class_heuristic_unit.sv
// ----------------------------------------------------------------------------
// flow_traffic_class_heuristic_unit
// Rule-based traffic classifier for flow summaries, three-stage pipeline.
//
//   channel  dir  fields
//   s_axis   in   tdata: flow summary, tuser: is_udp
//   m_axis   out  tdata: class_code, confidence_percent
//
// One request per cycle is taken while m_axis accepts, with the compare,
// rule and select stages each holding one request.
// Reset clears the stage valid bits only.
// A stalled m_axis holds its request; each stage still fills its own bubble.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flow_traffic_class_heuristic_unit
	import ftch_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// dest_port, source_port, mean_packet_size, packet_rate, byte_rate,
	// forward_ratio, zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// is_udp
	input  wire logic                   s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// class_code, confidence_percent, zero pad
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam int SP_LO = PORT_W;
	localparam int SZ_LO = SP_LO + PORT_W;
	localparam int PR_LO = SZ_LO + SIZE_W;
	localparam int BR_LO = PR_LO + RATE_W;
	localparam int FR_LO = BR_LO + BYTE_W;
	localparam int RES_W = CLASS_W + CONF_W;

	flow_t   flow;
	feat_t   feat;
	hits_t   hits;
	result_t res;
	logic    feat_valid;
	logic    feat_ready;
	logic    hits_valid;
	logic    hits_ready;

	always_comb begin
		flow.dest_port = s_axis_tdata[PORT_W-1:0];
		flow.source_port = s_axis_tdata[SP_LO +: PORT_W];
		flow.is_udp = s_axis_tuser;
		flow.mean_packet_size = s_axis_tdata[SZ_LO +: SIZE_W];
		flow.packet_rate = s_axis_tdata[PR_LO +: RATE_W];
		flow.byte_rate = s_axis_tdata[BR_LO +: BYTE_W];
		flow.forward_ratio = s_axis_tdata[FR_LO +: RATIO_W];
	end

	ftch_feat u_feat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_flow   (flow),
		.out_valid (feat_valid),
		.out_ready (feat_ready),
		.out_feat  (feat)
	);

	ftch_rule u_rule (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (feat_valid),
		.in_ready  (feat_ready),
		.in_feat   (feat),
		.out_valid (hits_valid),
		.out_ready (hits_ready),
		.out_hits  (hits)
	);

	ftch_sel u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hits_valid),
		.in_ready  (hits_ready),
		.in_hits   (hits),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W-RES_W){1'b0}}, res};

endmodule

`default_nettype wire

>>> design/ftch_feat.sv
// ----------------------------------------------------------------------------
// ftch_feat
// Stage 1: port matches and threshold compares on the flow summary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftch_feat
	import ftch_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire flow_t in_flow,
	output logic       out_valid,
	input  wire logic  out_ready,
	output feat_t      out_feat
);

	logic  valid_s1;
	feat_t feat_s1;
	feat_t feat_d;
	port_t dp;
	port_t sp;

	assign dp = in_flow.dest_port;
	assign sp = in_flow.source_port;

	always_comb begin
		feat_d.dns = (dp == P_DNS) || (sp == P_DNS);
		feat_d.infra = (dp == P_NTP) || (dp == P_SNMP) || (dp == P_MDNS);
		feat_d.sip = (dp == P_SIP) || (sp == P_SIP) || (dp == P_SIPS) || (sp == P_SIPS);
		feat_d.udp = in_flow.is_udp;
		feat_d.game_port = ((dp >= P_GAME_A_LO) && (dp <= P_GAME_A_HI)) ||
			((dp >= P_GAME_B_LO) && (dp <= P_GAME_B_HI)) ||
			(dp == P_STUN) || (dp == P_STUN_ALT);
		feat_d.port_443 = (dp == P_HTTPS) || (sp == P_HTTPS);
		feat_d.web_port = (dp == P_HTTPS) || (dp == P_HTTP) ||
			(sp == P_HTTPS) || (sp == P_HTTP);
		feat_d.sz_gt60 = in_flow.mean_packet_size > SZ_60;
		feat_d.sz_lt300 = in_flow.mean_packet_size < SZ_300;
		feat_d.sz_lt200 = in_flow.mean_packet_size < SZ_200;
		feat_d.sz_gt200 = in_flow.mean_packet_size > SZ_200;
		feat_d.sz_lt800 = in_flow.mean_packet_size < SZ_800;
		feat_d.sz_gt1000 = in_flow.mean_packet_size > SZ_1000;
		feat_d.sz_gt1200 = in_flow.mean_packet_size > SZ_1200;
		feat_d.pr_gt20 = in_flow.packet_rate > PR_20;
		feat_d.pr_lt120 = in_flow.packet_rate < PR_120;
		feat_d.pr_gt30 = in_flow.packet_rate > PR_30;
		feat_d.fr_mid = (in_flow.forward_ratio > FR_QUARTER) &&
			(in_flow.forward_ratio < FR_THREEQ);
		feat_d.fr_le015 = in_flow.forward_ratio <= FR_MAX_015;
		feat_d.fr_le010 = in_flow.forward_ratio <= FR_MAX_010;
		feat_d.fr_le005 = in_flow.forward_ratio <= FR_MAX_005;
		feat_d.br_gt5k = in_flow.byte_rate > BR_5K;
		feat_d.br_lt100k = in_flow.byte_rate < BR_100K;
		feat_d.br_gt100k = in_flow.byte_rate > BR_100K;
		feat_d.br_gt200k = in_flow.byte_rate > BR_200K;
		feat_d.br_gt500k = in_flow.byte_rate > BR_500K;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			feat_s1 <= feat_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_feat = feat_s1;

endmodule

`default_nettype wire

>>> design/ftch_rule.sv
// ----------------------------------------------------------------------------
// ftch_rule
// Stage 2: combines comparison flags into one match bit per rule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ftch_rule
	import ftch_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire feat_t in_feat,
	output logic       out_valid,
	input  wire logic  out_ready,
	output hits_t      out_hits
);

	logic  valid_s2;
	hits_t hits_s2;
	hits_t hits_d;
	feat_t f;

	assign f = in_feat;

	always_comb begin
		hits_d.dns = f.dns;
		hits_d.infra = f.infra;
		hits_d.sip = f.sip;
		hits_d.voice = f.udp && f.sz_gt60 && f.sz_lt300 && f.pr_gt20 &&
			f.pr_lt120 && f.fr_mid;
		hits_d.game_pat = f.udp && f.sz_lt200 && f.pr_gt30 && f.fr_mid;
		hits_d.game_port = f.udp && f.game_port;
		hits_d.video = f.br_gt100k && f.sz_gt1000 && f.fr_le015;
		hits_d.fast_dl = f.br_gt500k && f.fr_le005;
		hits_d.big_dl = f.br_gt200k && f.fr_le010 && f.sz_gt1200;
		hits_d.social = f.port_443 && f.br_gt5k && f.br_lt100k &&
			f.sz_gt200 && f.sz_lt800;
		hits_d.web = f.web_port;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hits_s2 <= hits_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_hits = hits_s2;

endmodule

`default_nettype wire

>>> design/ftch_sel.sv
// ----------------------------------------------------------------------------
// ftch_sel
// Stage 3: first matching rule picks class and confidence; output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "flow_traffic_class_heuristic_unit_defines.svh"

module ftch_sel
	import ftch_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire hits_t in_hits,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    out_res
);

	logic    valid_s3;
	result_t res_s3;
	result_t res_d;
	class_t  cls_s3;
	conf_t   conf_s3;

	always_comb begin
		priority if (in_hits.dns) begin
			res_d = '{confidence_percent: CONF_DNS, class_code: CLS_BROWSING};
		end else if (in_hits.infra) begin
			res_d = '{confidence_percent: CONF_INFRA, class_code: CLS_OTHER};
		end else if (in_hits.sip) begin
			res_d = '{confidence_percent: CONF_SIP, class_code: CLS_VOIP};
		end else if (in_hits.voice) begin
			res_d = '{confidence_percent: CONF_VOICE, class_code: CLS_VOIP};
		end else if (in_hits.game_pat) begin
			res_d = '{confidence_percent: CONF_GAME_PAT, class_code: CLS_GAMING};
		end else if (in_hits.game_port) begin
			res_d = '{confidence_percent: CONF_GAME_PORT, class_code: CLS_GAMING};
		end else if (in_hits.video) begin
			res_d = '{confidence_percent: CONF_VIDEO, class_code: CLS_VIDEO};
		end else if (in_hits.fast_dl) begin
			res_d = '{confidence_percent: CONF_FAST_DL, class_code: CLS_DOWNLOAD};
		end else if (in_hits.big_dl) begin
			res_d = '{confidence_percent: CONF_BIG_DL, class_code: CLS_DOWNLOAD};
		end else if (in_hits.social) begin
			res_d = '{confidence_percent: CONF_SOCIAL, class_code: CLS_SOCIAL};
		end else if (in_hits.web) begin
			res_d = '{confidence_percent: CONF_WEB, class_code: CLS_BROWSING};
		end else begin
			res_d = '{confidence_percent: CONF_FALLBACK, class_code: CLS_OTHER};
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_s3 <= res_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_res = res_s3;

	assign cls_s3 = res_s3.class_code;
	assign conf_s3 = res_s3.confidence_percent;

	`FTCH_ASSERT_NEXT(a_load, clk, arst_n, in_valid && in_ready, valid_s3)
	`FTCH_ASSERT_IMP(a_class_range, clk, arst_n, valid_s3, cls_s3 <= CLS_OTHER)
	`FTCH_ASSERT_IMP(a_conf_max, clk, arst_n, valid_s3, conf_s3 <= CONF_MAX)
	`FTCH_ASSERT_IMP(a_video_conf, clk, arst_n, valid_s3 && cls_s3 == CLS_VIDEO, conf_s3 == CONF_VIDEO)
	`FTCH_ASSERT_IMP(a_social_conf, clk, arst_n, valid_s3 && cls_s3 == CLS_SOCIAL, conf_s3 == CONF_SOCIAL)

endmodule

`default_nettype wire
